@@ design/sida_pkg.sv @@
// Shared types and constants for the shift insert/delete array.
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

	localparam int unsigned CMD_W = 3;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned VAL_W = 32;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_REMOVE     = 3'd2,
		CMD_REMOVE_RUN = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic [IDX_W-1:0]        index;
		logic [CNT_W-1:0]        run_length;
		logic signed [VAL_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        count;
		status_t                 status;
	} out_t;

	// What every cell of the chain does in a given cycle
	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_WRITE      = 3'd1,
		OP_SHIFT_UP   = 3'd2,
		OP_SHIFT_DOWN = 3'd3,
		OP_CLEAR      = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		logic [VAL_W-1:0] value;
	} cell_op_t;

endpackage
`default_nettype wire

@@ design/sida_cell.sv @@
// One slot of the chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sida_cell #(
	parameter int unsigned INDEX      = 0,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sida_pkg::cell_op_t     op,
	input  wire logic [DATA_WIDTH-1:0]  left,
	input  wire logic [DATA_WIDTH-1:0]  right,
	output logic      [DATA_WIDTH-1:0]  slot
);

	logic [DATA_WIDTH-1:0] slot_q;
	logic                  at_lo, above_lo, up_to_hi, below_hi, last_used;

	assign at_lo     = (INDEX == 32'(op.lo));
	assign above_lo  = (INDEX > 32'(op.lo));
	assign up_to_hi  = (INDEX <= 32'(op.hi));
	assign below_hi  = (INDEX < 32'(op.hi));
	assign last_used = ((INDEX + 1) >= 32'(op.hi));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			unique case (op.kind)
				sida_pkg::OP_WRITE: begin
					if (at_lo) slot_q <= DATA_WIDTH'(op.value);
				end
				sida_pkg::OP_SHIFT_UP: begin
					if (at_lo) slot_q <= DATA_WIDTH'(op.value);
					else if (above_lo && up_to_hi) slot_q <= left;
				end
				sida_pkg::OP_SHIFT_DOWN: begin
					// top slot within the capacity takes zero, the rest pull from above
					if ((at_lo || above_lo) && below_hi) slot_q <= last_used ? '0 : right;
				end
				sida_pkg::OP_CLEAR: begin
					if (at_lo || above_lo) slot_q <= '0;
				end
				default: begin
					slot_q <= slot_q;
				end
			endcase
		end
	end

	assign slot = slot_q;

endmodule
`default_nettype wire

@@ design/sida_ctrl.sv @@
// Command decode, fill count, capacity register and result register.
`timescale 1ns / 1ps
`default_nettype none
module sida_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire sida_pkg::in_t                   request,
	input  wire logic                            cfg_we,
	input  wire logic [sida_pkg::CNT_W-1:0]      cfg_wdata,
	input  wire logic [sida_pkg::VAL_W-1:0]      rd_data,
	output logic                                 busy,
	output logic                                 done,
	output sida_pkg::out_t                       result,
	output sida_pkg::cell_op_t                   op
);

	logic [sida_pkg::CNT_W-1:0] cap_q, fill_q, rem_q;
	logic [sida_pkg::IDX_W-1:0] start_q;
	logic                       busy_q, done_q;
	sida_pkg::out_t             res_q;

	logic [sida_pkg::CNT_W-1:0] cap_eff, cap_new, fill_d, rem_d, fill_dec, idx5;
	logic [sida_pkg::IDX_W-1:0] start_d;
	logic                       busy_d, done_d, acc;
	logic [sida_pkg::CNT_W:0]   run_end;
	sida_pkg::out_t             res_d;

	function automatic logic [sida_pkg::CNT_W-1:0] clamp_cap(
		input logic [sida_pkg::CNT_W-1:0] c);
		logic [sida_pkg::CNT_W-1:0] r;
		r = c;
		if (c == '0) r = sida_pkg::CNT_W'(1);
		else if (32'(c) > DEPTH) r = sida_pkg::CNT_W'(DEPTH);
		return r;
	endfunction

	assign acc      = start && !busy_q;
	assign cap_eff  = clamp_cap(cap_q);
	assign cap_new  = clamp_cap(cfg_wdata);
	assign fill_dec = (fill_q != '0) ? fill_q - 1'b1 : '0;
	assign idx5     = {1'b0, request.index};
	assign run_end  = {1'b0, idx5} + {1'b0, request.run_length};

	always_comb begin
		op         = '{kind: sida_pkg::OP_HOLD, lo: '0, hi: '0, value: request.value};
		fill_d     = fill_q;
		busy_d     = busy_q;
		rem_d      = rem_q;
		start_d    = start_q;
		done_d     = 1'b0;
		res_d      = '{read_value: '0, count: '0, status: sida_pkg::ST_OK};

		if (cfg_we) begin
			op.kind = sida_pkg::OP_CLEAR;
			op.lo   = cap_new;
			if (fill_q > cap_new) fill_d = cap_new;
		end else if (busy_q) begin
			// remove run in progress: one more downward shift per cycle while cfg_we is low
			op.kind = sida_pkg::OP_SHIFT_DOWN;
			op.lo   = {1'b0, start_q};
			op.hi   = cap_eff;
			fill_d  = fill_dec;
			rem_d   = rem_q - 1'b1;
			if (rem_q == sida_pkg::CNT_W'(1)) begin
				busy_d = 1'b0;
				done_d = 1'b1;
			end
		end else if (acc) begin
			done_d = 1'b1;
			case (request.command)
				sida_pkg::CMD_APPEND: begin
					if (fill_q >= cap_eff) begin
						res_d.status = sida_pkg::ST_FULL;
					end else begin
						op.kind = sida_pkg::OP_WRITE;
						op.lo   = fill_q;
						fill_d  = fill_q + 1'b1;
					end
				end
				sida_pkg::CMD_INSERT: begin
					if (idx5 >= cap_eff) begin
						res_d.status = sida_pkg::ST_RANGE;
					end else if (idx5 <= fill_q) begin
						if (fill_q >= cap_eff) begin
							res_d.status = sida_pkg::ST_FULL;
						end else begin
							op.kind = sida_pkg::OP_SHIFT_UP;
							op.lo   = idx5;
							op.hi   = fill_q;
							fill_d  = fill_q + 1'b1;
						end
					end else begin
						op.kind = sida_pkg::OP_WRITE;
						op.lo   = idx5;
						fill_d  = idx5 + 1'b1;
					end
				end
				sida_pkg::CMD_REMOVE: begin
					if (idx5 >= cap_eff) begin
						res_d.status = sida_pkg::ST_RANGE;
					end else begin
						op.kind = sida_pkg::OP_SHIFT_DOWN;
						op.lo   = idx5;
						op.hi   = cap_eff;
						fill_d  = fill_dec;
					end
				end
				sida_pkg::CMD_REMOVE_RUN: begin
					if (request.run_length == '0 || run_end > {1'b0, cap_eff}) begin
						res_d.status = sida_pkg::ST_RANGE;
					end else begin
						op.kind = sida_pkg::OP_SHIFT_DOWN;
						op.lo   = idx5;
						op.hi   = cap_eff;
						fill_d  = fill_dec;
						if (request.run_length != sida_pkg::CNT_W'(1)) begin
							busy_d  = 1'b1;
							rem_d   = request.run_length - 1'b1;
							start_d = request.index;
							done_d  = 1'b0;
						end
					end
				end
				sida_pkg::CMD_READ: begin
					if (idx5 >= cap_eff) res_d.status = sida_pkg::ST_RANGE;
					else res_d.read_value = rd_data;
				end
				default: begin
					res_d.status = sida_pkg::ST_RANGE;
				end
			endcase
		end
		res_d.count = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= sida_pkg::CAP_RESET;
			fill_q  <= '0;
			busy_q  <= 1'b0;
			rem_q   <= '0;
			start_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			fill_q  <= fill_d;
			busy_q  <= busy_d;
			rem_q   <= rem_d;
			start_q <= start_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) res_q <= res_d;
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_fill_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_eff)
		else $error("fill count above capacity");
	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("busy with no shifts left");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !cfg_we && rem_q == sida_pkg::CNT_W'(1)) |=> (done_q && !busy_q))
		else $error("remove run did not finish");
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(acc) || $past(busy_q)))
		else $error("result without a command");
`endif

endmodule
`default_nettype wire

@@ design/shift_insert_delete_array_top.sv @@
// Top level: controller plus the chain of slot cells.
`timescale 1ns / 1ps
`default_nettype none
// Ordered array with fill count, kept in a chain of slot registers. A command
// is taken when start is high and busy and cfg_we are low; its word appears
// on result in the next cycle with done high for that single cycle, and there
// is no way to hold it. Append, insert, remove, read and bad commands leave
// busy low, so a new command can follow on every cycle while cfg_we is low. A
// remove run of n entries moves the chain down one place per cycle, held while
// cfg_we is high; busy stays high until the last shift and the word comes the
// cycle after it. Capacity writes take effect at once and clear the slots
// above the new capacity in the same cycle. Reset clears every slot directly.
module shift_insert_delete_array_top #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire sida_pkg::in_t                request,
	output logic                              busy,
	output logic                              done,
	output sida_pkg::out_t                    result,
	input  wire logic                         cfg_we,
	input  wire logic [sida_pkg::CNT_W-1:0]   cfg_wdata
);

	logic [DATA_WIDTH-1:0]      slot [DEPTH];
	logic [sida_pkg::VAL_W-1:0] rd_data;
	sida_pkg::cell_op_t         op;

	sida_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rd_data   (rd_data),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.op        (op)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = slot[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = slot[i+1];
		end
		sida_cell #(.INDEX(i), .DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (left_w),
			.right  (right_w),
			.slot   (slot[i])
		);
	end

	// read bus: each cell drives only when addressed
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (32'(request.index) == 32'(i)) rd_data = rd_data | sida_pkg::VAL_W'(slot[i]);
		end
	end

endmodule
`default_nettype wire

@@ verif/shift_insert_delete_array_top_tb.sv @@
// Testbench for shift_insert_delete_array_top: directed table plus random commands.
`timescale 1ns / 1ps
module shift_insert_delete_array_top_tb;

	localparam int unsigned SLOT_COUNT  = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SEG_WORDS   = 80;
	localparam logic [sida_pkg::CMD_W-1:0] CMD_BAD_LO = 3'd5;
	localparam logic [sida_pkg::CMD_W-1:0] CMD_BAD_HI = 3'd7;

	typedef struct {
		sida_pkg::in_t  word;
		bit             typed;
		sida_pkg::out_t want;
	} step_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	sida_pkg::in_t              request = '0;
	logic                       busy;
	logic                       done;
	sida_pkg::out_t             result;
	logic                       cfg_we = 1'b0;
	logic [sida_pkg::CNT_W-1:0] cfg_wdata = '0;

	// driven next to request: a typed expectation for this word, if any
	bit             typed_now = 1'b0;
	sida_pkg::out_t typed_want = '0;

	// shadow of the array
	logic [sida_pkg::VAL_W-1:0] slot_img [SLOT_COUNT];
	int unsigned                fill_img = 0;
	logic [sida_pkg::CNT_W-1:0] cap_reg = sida_pkg::CAP_RESET;

	sida_pkg::out_t awaited_results [$];
	sida_pkg::out_t head, predicted;
	int unsigned    fails = 0;
	int unsigned    cycles = 0;
	int unsigned    idle_pct = 0;
	step_row_t      plan [$];

	shift_insert_delete_array_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic int unsigned cap_in_use(input logic [sida_pkg::CNT_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > SLOT_COUNT)
			return SLOT_COUNT;
		return 32'(v);
	endfunction

	function automatic void set_capacity(input logic [sida_pkg::CNT_W-1:0] v);
		int unsigned c;
		c = cap_in_use(v);
		cap_reg = v;
		if (fill_img > c)
			fill_img = c;
		for (int unsigned i = c; i < SLOT_COUNT; i++)
			slot_img[i] = '0;
	endfunction

	function automatic void drop_entries(input int unsigned first, input int unsigned n,
			input int unsigned c);
		for (int unsigned i = first; i < c; i++)
			slot_img[i] = (i + n < c) ? slot_img[i + n] : '0;
		fill_img = (fill_img > n) ? fill_img - n : 0;
	endfunction

	function automatic sida_pkg::out_t run_command(input sida_pkg::in_t w);
		int unsigned c, idx, n;
		sida_pkg::out_t r;
		c = cap_in_use(cap_reg);
		idx = 32'(w.index);
		n = 32'(w.run_length);
		r = '0;
		r.status = sida_pkg::ST_OK;
		case (w.command)
			sida_pkg::CMD_APPEND: begin
				if (fill_img >= c) begin
					r.status = sida_pkg::ST_FULL;
				end else begin
					slot_img[fill_img] = w.value;
					fill_img++;
				end
			end
			sida_pkg::CMD_INSERT: begin
				if (idx >= c) begin
					r.status = sida_pkg::ST_RANGE;
				end else if (idx <= fill_img) begin
					if (fill_img >= c) begin
						r.status = sida_pkg::ST_FULL;
					end else begin
						for (int unsigned i = fill_img; i > idx; i--)
							slot_img[i] = slot_img[i - 1];
						slot_img[idx] = w.value;
						fill_img++;
					end
				end else begin
					// past the fill count: skipped slots keep their contents
					slot_img[idx] = w.value;
					fill_img = idx + 1;
				end
			end
			sida_pkg::CMD_REMOVE: begin
				if (idx >= c)
					r.status = sida_pkg::ST_RANGE;
				else
					drop_entries(idx, 1, c);
			end
			sida_pkg::CMD_REMOVE_RUN: begin
				if (n == 0 || idx + n > c)
					r.status = sida_pkg::ST_RANGE;
				else
					drop_entries(idx, n, c);
			end
			sida_pkg::CMD_READ: begin
				if (idx >= c)
					r.status = sida_pkg::ST_RANGE;
				else
					r.read_value = slot_img[idx];
			end
			default: r.status = sida_pkg::ST_RANGE;
		endcase
		r.count = fill_img[sida_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic step_row_t dir_row(input logic [sida_pkg::CMD_W-1:0] cmd,
			input logic [sida_pkg::IDX_W-1:0] idx, input logic [sida_pkg::CNT_W-1:0] run,
			input logic [sida_pkg::VAL_W-1:0] val, input bit typed,
			input logic [sida_pkg::VAL_W-1:0] rd,
			input logic [sida_pkg::CNT_W-1:0] cnt, input sida_pkg::status_t st);
		step_row_t r;
		r.word = '{command: cmd, index: idx, run_length: run, value: val};
		r.typed = typed;
		r.want = '{read_value: rd, count: cnt, status: st};
		return r;
	endfunction

	function automatic sida_pkg::in_t random_word(input int unsigned c);
		sida_pkg::in_t w;
		int unsigned pick, idx;
		pick = $urandom_range(99);
		if (pick < 30)
			w.command = sida_pkg::CMD_APPEND;
		else if (pick < 55)
			w.command = sida_pkg::CMD_INSERT;
		else if (pick < 68)
			w.command = sida_pkg::CMD_REMOVE;
		else if (pick < 78)
			w.command = sida_pkg::CMD_REMOVE_RUN;
		else if (pick < 96)
			w.command = sida_pkg::CMD_READ;
		else
			w.command = sida_pkg::CMD_W'($urandom_range(CMD_BAD_HI, CMD_BAD_LO));
		idx = ($urandom_range(99) < 85) ? $urandom_range(c - 1) : $urandom_range(15);
		w.index = sida_pkg::IDX_W'(idx);
		if ($urandom_range(99) < 85 && idx < c)
			w.run_length = sida_pkg::CNT_W'($urandom_range(c - idx, 1));
		else
			w.run_length = sida_pkg::CNT_W'($urandom_range(31));
		case ($urandom_range(9))
			0: w.value = 32'h7fff_ffff;
			1: w.value = 32'h8000_0000;
			2: w.value = '0;
			3: w.value = '1;
			default: w.value = $urandom;
		endcase
		return w;
	endfunction

	task automatic send_word(input sida_pkg::in_t w, input bit typed,
			input sida_pkg::out_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= w;
		typed_now <= typed;
		typed_want <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every awaited word is in; sampled away from the active edge
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [sida_pkg::CNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// checker and predictor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result word with nothing awaited: read_value %0d count %0d status %0d",
						result.read_value, result.count, result.status);
					fails++;
				end else begin
					head = awaited_results.pop_front();
					if (result.read_value !== head.read_value) begin
						$error("read_value: expected %0d, actual %0d", head.read_value,
							result.read_value);
						fails++;
					end
					if (result.count !== head.count) begin
						$error("count: expected %0d, actual %0d", head.count, result.count);
						fails++;
					end
					if (result.status !== head.status) begin
						$error("status: expected %0d, actual %0d", head.status, result.status);
						fails++;
					end
				end
			end
			if (cfg_we)
				set_capacity(cfg_wdata);
			if (start && !busy) begin
				predicted = run_command(request);
				awaited_results.push_back(typed_now ? typed_want : predicted);
			end
		end
	end

	initial begin
		logic [sida_pkg::CNT_W-1:0] seg_caps [8];
		int unsigned c;

		seg_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd6, 5'd17, 5'd3, 5'd16};
		for (int unsigned i = 0; i < SLOT_COUNT; i++)
			slot_img[i] = '0;

		// capacity is 10 out of reset, count 0, store all zero
		plan.push_back(dir_row(sida_pkg::CMD_READ, 0, 1, 0, 1, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE, 0, 1, 0, 1, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_READ, 15, 1, 0, 1, 0, 0, sida_pkg::ST_RANGE));
		plan.push_back(dir_row(CMD_BAD_LO, 0, 1, 0, 1, 0, 0, sida_pkg::ST_RANGE));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h7fff_ffff, 1, 0, 1,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h8000_0000, 1, 0, 2,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_READ, 1, 1, 0, 1, 32'h8000_0000, 2,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_INSERT, 0, 1, 32'hffff_ffff, 1, 0, 3,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_INSERT, 6, 1, 32'h1234_5678, 1, 0, 7,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_INSERT, 10, 1, 32'h5555_aaaa, 1, 0, 7,
			sida_pkg::ST_RANGE));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE_RUN, 2, 0, 0, 1, 0, 7, sida_pkg::ST_RANGE));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE_RUN, 5, 6, 0, 1, 0, 7, sida_pkg::ST_RANGE));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE, 9, 1, 0, 1, 0, 6, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE_RUN, 1, 2, 0, 0, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h0000_0001, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'hfedc_ba98, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h0f0f_0f0f, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'hf0f0_f0f0, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h3333_cccc, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'hcccc_3333, 0, 0, 0,
			sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_APPEND, 0, 1, 32'h1111_1111, 1, 0, 10,
			sida_pkg::ST_FULL));
		plan.push_back(dir_row(sida_pkg::CMD_INSERT, 3, 1, 32'h2222_2222, 1, 0, 10,
			sida_pkg::ST_FULL));
		plan.push_back(dir_row(sida_pkg::CMD_INSERT, 9, 1, 32'h4444_4444, 1, 0, 10,
			sida_pkg::ST_FULL));
		plan.push_back(dir_row(sida_pkg::CMD_READ, 9, 1, 0, 0, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE_RUN, 0, 10, 0, 1, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_READ, 9, 1, 0, 1, 0, 0, sida_pkg::ST_OK));
		plan.push_back(dir_row(sida_pkg::CMD_REMOVE_RUN, 0, 31, 0, 1, 0, 0,
			sida_pkg::ST_RANGE));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 17;
		foreach (plan[i])
			send_word(plan[i].word, plan[i].typed, plan[i].want);

		for (int unsigned seg = 0; seg < 8; seg++) begin
			idle_pct = (seg < 3) ? 17 : (seg < 6) ? 49 : 0;
			write_capacity(seg_caps[seg]);
			c = cap_in_use(seg_caps[seg]);
			for (int unsigned n = 0; n < SEG_WORDS; n++)
				send_word(random_word(c), 1'b0, '0);
		end

		drain();
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
design/sida_pkg.sv
design/sida_cell.sv
design/sida_ctrl.sv
design/shift_insert_delete_array_top.sv
verif/shift_insert_delete_array_top_tb.sv
